FILE: sv/sha256_block_hasher_assert.svh
// Assertion macros for the SHA-256 block hasher.
`ifndef SHA256_BLOCK_HASHER_ASSERT_SVH
`define SHA256_BLOCK_HASHER_ASSERT_SVH

`ifndef ASSERT_OFF
`define SHABH_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("shabh assertion failed");
`define SHABH_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("shabh forbidden condition");
`else
`define SHABH_ASSERT(lbl, clk, rst_n, prop)
`define SHABH_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

FILE: sv/shabh_pkg.sv
// Types, constants and round functions shared by the SHA-256 block hasher.
package shabh_pkg;

	localparam int ROUNDS      = 64;
	localparam int BLOCK_WORDS = 16;
	localparam int HASH_WORDS  = 8;
	localparam int WORD_W      = 32;
	localparam int ROUND_W     = $clog2(ROUNDS);
	localparam int WCNT_W      = $clog2(BLOCK_WORDS);
	localparam int OCNT_W      = $clog2(HASH_WORDS + 1);

	localparam logic [WORD_W-1:0] HASH_IV [HASH_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic               load_word;
		logic               start;
		logic               round;
		logic [ROUND_W-1:0] round_idx;
		logic               add;
		logic               emit;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_stat_t;

	function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	function automatic logic [WORD_W-1:0] round_const(input logic [ROUND_W-1:0] t);
		logic [WORD_W-1:0] k;
		case (t)
			6'd0:  k = 32'h428a2f98;
			6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;
			6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;
			6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;
			6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;
			6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;
			6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;
			6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;
			6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;
			6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;
			6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;
			6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;
			6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;
			6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;
			6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;
			6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;
			6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;
			6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;
			6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;
			6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;
			6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;
			6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;
			6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;
			6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;
			6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

endpackage

FILE: sv/sha256_block_hasher.sv
// Top level of the SHA-256 block hasher.
// Input channel s_*: one padded big-endian message word per request in s_tdata,
//   s_tlast set on the final word of the final block of a message; s_tlast on a
//   word that does not close a 16-word block is ignored.
// Output channel m_*: the eight digest words H0..H7 in m_tdata, m_tlast on H7.
// Sequence: a block takes 16 accepted words, then 64 rounds (one round per
//   cycle through the round logic that all rounds share) and one hash update.
//   s_tready is low during rounds and update. For a marked block the digest is
//   copied into the output register in the emit state after the update, once
//   the previous digest has drained.
// The output register frees the input side: the next message is collected
//   while the digest drains. If the receiver stalls, a following digest waits
//   in the controller until the previous one has been taken, and input stops.
// Reset: arst_n clears the controller, empties the output register and loads
//   the standard initial hash value; input is accepted right after reset.
module sha256_block_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] message_word
	input  logic        s_tlast,   // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic        m_tlast    // digest_last
);
	import shabh_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	shabh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.dp_stat  (dp_stat),
		.dp_cmd   (dp_cmd)
	);

	shabh_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.dp_cmd       (dp_cmd),
		.dp_stat      (dp_stat),
		.message_word (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast)
	);

`include "sha256_block_hasher_assert.svh"

	`SHABH_ASSERT_NEVER(a_no_request_in_rounds, clk, arst_n, dp_cmd.round && s_tready)
	`SHABH_ASSERT(a_emit_when_empty, clk, arst_n, dp_cmd.emit |-> !m_tvalid)
	`SHABH_ASSERT(a_emit_shows_digest, clk, arst_n, dp_cmd.emit |=> (m_tvalid && !m_tlast))
	`SHABH_ASSERT_NEVER(a_single_step, clk, arst_n, dp_cmd.round && (dp_cmd.add || dp_cmd.start))

endmodule

FILE: sv/shabh_ctrl.sv
// Sequencer for word collection, compression rounds, hash update and digest hand-off.
module shabh_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                s_tlast,
	input  shabh_pkg::dp_stat_t dp_stat,
	output shabh_pkg::dp_cmd_t  dp_cmd
);
	import shabh_pkg::*;

	state_t              state_q, state_d;
	logic [WCNT_W-1:0]   word_cnt_q, word_cnt_d;
	logic [ROUND_W-1:0]  round_q, round_d;
	logic                last_q, last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_COLLECT;
			word_cnt_q <= '0;
			round_q    <= '0;
			last_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			word_cnt_q <= word_cnt_d;
			round_q    <= round_d;
			last_q     <= last_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		word_cnt_d = word_cnt_q;
		round_d    = round_q;
		last_d     = last_q;
		s_tready   = 1'b0;
		dp_cmd     = '0;
		dp_cmd.round_idx = round_q;
		case (state_q)
			ST_COLLECT: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					dp_cmd.load_word = 1'b1;
					word_cnt_d = word_cnt_q + 1'b1;
					if (word_cnt_q == WCNT_W'(BLOCK_WORDS - 1)) begin
						dp_cmd.start = 1'b1;
						last_d  = s_tlast;
						round_d = '0;
						state_d = ST_ROUND;
					end
				end
			end
			ST_ROUND: begin
				dp_cmd.round = 1'b1;
				round_d = round_q + 1'b1;
				if (round_q == ROUND_W'(ROUNDS - 1))
					state_d = ST_ADD;
			end
			ST_ADD: begin
				dp_cmd.add = 1'b1;
				state_d = last_q ? ST_EMIT : ST_COLLECT;
			end
			ST_EMIT: begin
				// hold until the previous digest has drained
				if (!dp_stat.out_busy) begin
					dp_cmd.emit = 1'b1;
					state_d = ST_COLLECT;
				end
			end
			default: state_d = ST_COLLECT;
		endcase
	end

endmodule

FILE: sv/shabh_datapath.sv
// Message schedule, working variables, hash state and digest output register.
module shabh_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  shabh_pkg::dp_cmd_t  dp_cmd,
	output shabh_pkg::dp_stat_t dp_stat,
	input  logic [31:0]         message_word,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,
	output logic                m_tlast
);
	import shabh_pkg::*;

	logic [WORD_W-1:0] sched_q [BLOCK_WORDS];
	logic [WORD_W-1:0] work_q  [HASH_WORDS];
	logic [WORD_W-1:0] hash_q  [HASH_WORDS];
	logic [WORD_W-1:0] out_q   [HASH_WORDS];
	logic [OCNT_W-1:0] out_cnt_q;

	logic [WORD_W-1:0] w_next;
	logic [WORD_W-1:0] t1;
	logic [WORD_W-1:0] t2;
	logic [WORD_W-1:0] ch;
	logic [WORD_W-1:0] maj;
	logic              out_take;

	assign w_next = small_sigma1(sched_q[14]) + sched_q[9]
	              + small_sigma0(sched_q[1]) + sched_q[0];
	assign ch     = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
	assign maj    = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2])
	              ^ (work_q[1] & work_q[2]);
	assign t1     = work_q[7] + big_sigma1(work_q[4]) + ch
	              + round_const(dp_cmd.round_idx) + sched_q[0];
	assign t2     = big_sigma0(work_q[0]) + maj;

	assign m_tvalid = (out_cnt_q != '0);
	assign m_tdata  = out_q[0];
	assign m_tlast  = (out_cnt_q == OCNT_W'(1));
	assign out_take = m_tvalid && m_tready;
	assign dp_stat.out_busy = m_tvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HASH_WORDS; i++)
				hash_q[i] <= HASH_IV[i];
			out_cnt_q <= '0;
		end else begin
			if (dp_cmd.add) begin
				for (int i = 0; i < HASH_WORDS; i++)
					hash_q[i] <= hash_q[i] + work_q[i];
			end else if (dp_cmd.emit) begin
				for (int i = 0; i < HASH_WORDS; i++)
					hash_q[i] <= HASH_IV[i];
			end
			if (dp_cmd.emit)
				out_cnt_q <= OCNT_W'(HASH_WORDS);
			else if (out_take)
				out_cnt_q <= out_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load_word) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++)
				sched_q[i] <= sched_q[i+1];
			sched_q[BLOCK_WORDS-1] <= message_word;
		end else if (dp_cmd.round) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++)
				sched_q[i] <= sched_q[i+1];
			sched_q[BLOCK_WORDS-1] <= w_next;
		end

		if (dp_cmd.start) begin
			for (int i = 0; i < HASH_WORDS; i++)
				work_q[i] <= hash_q[i];
		end else if (dp_cmd.round) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end

		if (dp_cmd.emit) begin
			for (int i = 0; i < HASH_WORDS; i++)
				out_q[i] <= hash_q[i];
		end else if (out_take) begin
			for (int i = 0; i < HASH_WORDS - 1; i++)
				out_q[i] <= out_q[i+1];
		end
	end

endmodule
